// ===== hw/rtl/imu_pkg.sv =====
// Shared types, constants and the CORDIC angle table for the IMU sample processor.
`timescale 1ns / 1ps

package imu_pkg;

    typedef struct packed {
        logic signed [15:0] acc_x;
        logic signed [15:0] acc_y;
        logic signed [15:0] acc_z;
        logic signed [15:0] rot_x;
        logic signed [15:0] rot_y;
        logic signed [15:0] rot_z;
        logic [15:0]        elapsed_ms;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] angle_x;
        logic signed [31:0] angle_y;
        logic signed [31:0] angle_z;
        logic signed [15:0] tilt_x;
        logic signed [15:0] tilt_y;
    } out_item_t;

    // One queued sample after classification: gyro rates as sign and magnitude.
    typedef struct packed {
        logic [2:0][19:0]   rate_mag;
        logic [2:0]         rate_neg;
        logic [15:0]        elapsed_ms;
        logic signed [15:0] acc_x;
        logic signed [15:0] acc_y;
        logic signed [15:0] acc_z;
    } work_t;

    localparam logic [1:0] CFG_BIAS_X = 2'd0;
    localparam logic [1:0] CFG_BIAS_Y = 2'd1;
    localparam logic [1:0] CFG_BIAS_Z = 2'd2;

    localparam int DEF_CORDIC_STEPS    = 16;
    localparam int DEF_ANGLE_FRAC_BITS = 16;

    // The rate divisor 164000 is 32 * 5125; the power of two folds into the fraction shift.
    // Multiplying by the reciprocal and shifting right by 45 gives the exact floor quotient
    // by 5125 for any 32-bit dividend.
    localparam logic [12:0] RATE_DIV         = 13'd5125;
    localparam logic [32:0] RATE_RECIP       = 33'd6865243335;
    localparam int          RATE_RECIP_SHIFT = 45;
    localparam logic [11:0] RATE_ROUND       = 12'd2562;

    localparam logic signed [17:0] NINETY_Q8 = 18'sd23040;

    function automatic logic [21:0] atan_deg_q16(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0: v = 22'd2949120;
            5'd1: v = 22'd1740967;
            5'd2: v = 22'd919879;
            5'd3: v = 22'd466945;
            5'd4: v = 22'd234379;
            5'd5: v = 22'd117304;
            5'd6: v = 22'd58666;
            5'd7: v = 22'd29335;
            5'd8: v = 22'd14668;
            5'd9: v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/imu_gyro_integrate_accel_tilt_unit.sv =====
// Top level of the IMU sample processor: gyro angle integration and accelerometer tilt.
// Each sample is processed serially in the back stage, which uses the square root and CORDIC
// in turn and takes no new sample until the last result is registered; a zero tilt
// denominator skips that tilt's root and CORDIC. A two-entry queue buffers input.
// Reset (aresetn low, synchronous) clears the angle accumulators, biases and all handshakes.
`timescale 1ns / 1ps

module imu_gyro_integrate_accel_tilt_unit import imu_pkg::*; #(
    parameter int CORDIC_STEPS    = DEF_CORDIC_STEPS,
    parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    logic  fq_valid;
    logic  fq_ready;
    work_t fq_data;
    logic  qb_valid;
    logic  qb_ready;
    work_t qb_data;

    imu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_data    (fq_data)
    );

    imu_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    imu_back #(
        .CORDIC_STEPS    (CORDIC_STEPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== hw/rtl/imu_front.sv =====
// Front stage: bias registers, sample transfer and gyro rate classification.
`timescale 1ns / 1ps

module imu_front import imu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        q_valid,
    input  logic        q_ready,
    output work_t       q_data
);

    logic signed [10:0] bias_reg [3];
    logic               valid_reg;
    work_t              work_reg;
    work_t              work_next;
    logic signed [15:0] raw [3];
    logic signed [20:0] rate [3];

    assign raw[0] = s_data.rot_x;
    assign raw[1] = s_data.rot_y;
    assign raw[2] = s_data.rot_z;

    always_comb begin
        work_next            = '0;
        work_next.elapsed_ms = s_data.elapsed_ms;
        work_next.acc_x      = s_data.acc_x;
        work_next.acc_y      = s_data.acc_y;
        work_next.acc_z      = s_data.acc_z;
        for (int i = 0; i < 3; i++) begin
            rate[i] = (21'(raw[i]) <<< 2) + 21'(raw[i]) - 21'(bias_reg[i]) * 21'sd164;
            work_next.rate_neg[i] = rate[i][20];
            work_next.rate_mag[i] = rate[i][20] ? 20'(-rate[i]) : 20'(rate[i]);
        end
    end

    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_data  = work_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            bias_reg[0] <= '0;
            bias_reg[1] <= '0;
            bias_reg[2] <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_BIAS_X: bias_reg[0] <= cfg_wdata;
                    CFG_BIAS_Y: bias_reg[1] <= cfg_wdata;
                    CFG_BIAS_Z: bias_reg[2] <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                valid_reg <= 1'b1;
                work_reg  <= work_next;
            end else if (q_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== hw/rtl/imu_queue.sv =====
// Two-entry queue between the front and back stages.
`timescale 1ns / 1ps

module imu_queue import imu_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    output logic  push_ready,
    input  work_t push_data,
    output logic  pop_valid,
    input  logic  pop_ready,
    output work_t pop_data
);

    work_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                mem_reg[wr_ptr_reg] <= push_data;
                wr_ptr_reg          <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== hw/rtl/imu_back.sv =====
// Back stage: angle integration by reciprocal division, tilt by square root and CORDIC.
`timescale 1ns / 1ps

module imu_back import imu_pkg::*; #(
    parameter int CORDIC_STEPS    = DEF_CORDIC_STEPS,
    parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    output logic      q_ready,
    input  work_t     q_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int CW  = 5;
    localparam int QSH = ANGLE_FRAC_BITS - 5;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MUL, ST_REM1, ST_TMUL, ST_DIV, ST_REM2, ST_RND, ST_FIN, ST_ACC,
        ST_SQ1, ST_SQ2, ST_SQINIT, ST_SQRT, ST_CINIT, ST_CORD, ST_CRND, ST_DONE
    } state_t;

    state_t             state_reg;
    work_t              work_reg;
    logic [1:0]         axis_reg;
    logic               tsel_reg;
    logic [CW-1:0]      cnt_reg;
    logic [7:0]         a_reg;
    logic [12:0]        b_reg;
    logic [28:0]        t_reg;
    logic [23:0]        qa_reg;
    logic [16:0]        c_reg;
    logic [31:0]        q_reg;
    logic [12:0]        r_reg;
    logic [31:0]        v_reg;
    logic [19:0]        f_reg;
    logic [31:0]        acc_reg [3];
    logic signed [31:0] sq_reg;
    logic [31:0]        s_reg;
    logic [63:0]        rad_reg;
    logic [31:0]        root_reg;
    logic [33:0]        srem_reg;
    logic signed [35:0] x_reg;
    logic signed [35:0] y_reg;
    logic signed [25:0] z_reg;
    logic signed [15:0] tilt_reg [2];
    logic               m_valid_reg;
    out_item_t          m_data_reg;

    logic [19:0]        mag;
    logic [31:0]        dv_in;
    logic [64:0]        dv_prod;
    logic [19:0]        dv_q;
    logic [31:0]        quo;
    logic signed [16:0] num_t;
    logic signed [15:0] opa;
    logic signed [15:0] opb;
    logic [35:0]        srem_sh;
    logic [35:0]        trial;
    logic signed [35:0] dx;
    logic signed [35:0] dy;
    logic signed [25:0] tab;
    logic signed [25:0] zr;
    logic signed [17:0] rq;

    always_comb begin
        mag = work_reg.rate_mag[axis_reg];
        if (state_reg == ST_MUL) begin
            dv_in = 32'(mag);
        end else if (state_reg == ST_DIV) begin
            dv_in = 32'(t_reg);
        end else begin
            dv_in = v_reg;
        end
        dv_prod = 65'(dv_in) * 65'(RATE_RECIP);
        dv_q    = 20'(dv_prod >> RATE_RECIP_SHIFT);
        quo     = (q_reg << QSH) + 32'(f_reg);
        num_t   = tsel_reg ? -17'(work_reg.acc_x) : 17'(work_reg.acc_y);
        opa     = tsel_reg ? work_reg.acc_y : work_reg.acc_x;
        opb     = work_reg.acc_z;
        srem_sh = {srem_reg, rad_reg[63:62]};
        trial   = {2'b00, root_reg, 2'b01};
        dx      = y_reg >>> cnt_reg;
        dy      = x_reg >>> cnt_reg;
        tab     = 26'(atan_deg_q16(cnt_reg[4:0]));
        zr      = z_reg + 26'sd128;
        rq      = 18'(zr >>> 8);
    end

    assign q_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            acc_reg[0]  <= '0;
            acc_reg[1]  <= '0;
            acc_reg[2]  <= '0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        work_reg  <= q_data;
                        axis_reg  <= 2'd0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    a_reg     <= dv_q[7:0];
                    state_reg <= ST_REM1;
                end
                ST_REM1: begin
                    b_reg     <= 13'(mag - 20'(a_reg) * 20'(RATE_DIV));
                    state_reg <= ST_TMUL;
                end
                ST_TMUL: begin
                    t_reg     <= 29'(b_reg) * 29'(work_reg.elapsed_ms);
                    qa_reg    <= 24'(a_reg) * 24'(work_reg.elapsed_ms);
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    c_reg     <= dv_q[16:0];
                    state_reg <= ST_REM2;
                end
                ST_REM2: begin
                    q_reg     <= 32'(qa_reg) + 32'(c_reg);
                    r_reg     <= 13'(t_reg - 29'(c_reg) * 29'(RATE_DIV));
                    state_reg <= ST_RND;
                end
                ST_RND: begin
                    v_reg     <= (32'(r_reg) << QSH) + 32'(RATE_ROUND);
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    f_reg     <= dv_q;
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    acc_reg[axis_reg] <= acc_reg[axis_reg]
                        + (work_reg.rate_neg[axis_reg] ? -quo : quo);
                    if (axis_reg == 2'd2) begin
                        tsel_reg  <= 1'b0;
                        state_reg <= ST_SQ1;
                    end else begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_SQ1: begin
                    sq_reg    <= 32'(opa) * 32'(opa);
                    state_reg <= ST_SQ2;
                end
                ST_SQ2: begin
                    s_reg     <= 32'(sq_reg + 32'(opb) * 32'(opb));
                    state_reg <= ST_SQINIT;
                end
                ST_SQINIT: begin
                    if (s_reg == '0) begin
                        tilt_reg[tsel_reg] <= (num_t > 0) ? 16'(NINETY_Q8)
                                            : ((num_t < 0) ? 16'(-NINETY_Q8) : 16'sd0);
                        if (tsel_reg) begin
                            state_reg <= ST_DONE;
                        end else begin
                            tsel_reg  <= 1'b1;
                            state_reg <= ST_SQ1;
                        end
                    end else begin
                        rad_reg   <= {s_reg, 32'd0};
                        root_reg  <= '0;
                        srem_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (srem_sh >= trial) begin
                        srem_reg <= 34'(srem_sh - trial);
                        root_reg <= {root_reg[30:0], 1'b1};
                    end else begin
                        srem_reg <= srem_sh[33:0];
                        root_reg <= {root_reg[30:0], 1'b0};
                    end
                    rad_reg <= rad_reg << 2;
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(31)) begin
                        state_reg <= ST_CINIT;
                    end
                end
                ST_CINIT: begin
                    x_reg     <= 36'(root_reg);
                    y_reg     <= 36'(num_t) <<< 16;
                    z_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_CORD;
                end
                ST_CORD: begin
                    if (y_reg > 0) begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + tab;
                    end else begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - tab;
                    end
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(CORDIC_STEPS - 1)) begin
                        state_reg <= ST_CRND;
                    end
                end
                ST_CRND: begin
                    if (rq > NINETY_Q8) begin
                        tilt_reg[tsel_reg] <= 16'(NINETY_Q8);
                    end else if (rq < -NINETY_Q8) begin
                        tilt_reg[tsel_reg] <= 16'(-NINETY_Q8);
                    end else begin
                        tilt_reg[tsel_reg] <= 16'(rq);
                    end
                    if (tsel_reg) begin
                        state_reg <= ST_DONE;
                    end else begin
                        tsel_reg  <= 1'b1;
                        state_reg <= ST_SQ1;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg        <= 1'b1;
                        m_data_reg.angle_x <= acc_reg[0];
                        m_data_reg.angle_y <= acc_reg[1];
                        m_data_reg.angle_z <= acc_reg[2];
                        m_data_reg.tilt_x  <= tilt_reg[0];
                        m_data_reg.tilt_y  <= tilt_reg[1];
                        state_reg          <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the IMU gyro integration and accelerometer tilt unit.
`timescale 1ns / 1ps

module testbench;
    import imu_pkg::*;

    localparam logic [1:0] CFG_NONE = 2'd3;
    localparam int         STEPS = 16;
    localparam int         STALL_LIMIT = 20000;
    localparam longint     ATAN_Q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [10:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;

    in_item_t    sample_q[$];
    out_item_t   result_q[$];
    logic signed [10:0] gyro_bias[3] = '{0, 0, 0};
    logic [31:0] heading_acc[3] = '{0, 0, 0};
    int          send_idle = 0;
    int          recv_stall = 0;
    int          hold_request = 0;
    int          hold_count = 0;
    int          errors = 0;
    int          quiet_cycles = 0;

    imu_gyro_integrate_accel_tilt_unit u_top (.*);

    always #5 aclk = ~aclk;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] tilt_q8(longint n, longint a, longint b);
        longint unsigned s;
        longint x, y, z, dx, dy, r;
        s = a * a + b * b;
        if (s == 0) begin
            r = n > 0 ? 23040 : (n < 0 ? -23040 : 0);
            return r[15:0];
        end
        x = int_sqrt(s << 32);
        y = n * 65536;
        z = 0;
        for (int i = 0; i < STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx;
                y -= dy;
                z += ATAN_Q16[i];
            end else begin
                x -= dx;
                y += dy;
                z -= ATAN_Q16[i];
            end
        end
        r = (z + 128) >>> 8;
        if (r > 23040) r = 23040;
        if (r < -23040) r = -23040;
        return r[15:0];
    endfunction

    function automatic out_item_t integrate_sample(in_item_t d);
        out_item_t o;
        longint raw, num, mag, q;
        for (int i = 0; i < 3; i++) begin
            raw = (i == 0) ? d.rot_x : (i == 1) ? d.rot_y : d.rot_z;
            num = (5 * raw - 164 * longint'(gyro_bias[i])) * longint'(d.elapsed_ms) * 65536;
            mag = num < 0 ? -num : num;
            q = (mag + 82000) / 164000;
            if (num < 0) q = -q;
            heading_acc[i] = heading_acc[i] + q[31:0];
        end
        o.angle_x = heading_acc[0];
        o.angle_y = heading_acc[1];
        o.angle_z = heading_acc[2];
        o.tilt_x = tilt_q8(d.acc_y, d.acc_x, d.acc_z);
        o.tilt_y = tilt_q8(-longint'(d.acc_x), d.acc_y, d.acc_z);
        return o;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) result_q.push_back(integrate_sample(s_data));
            if (s_valid && !s_ready) begin
                s_valid <= 1'b1;
            end else if (sample_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                s_data <= sample_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result transfer %h", $time, m_data);
                errors++;
            end else begin
                e = result_q.pop_front();
                if (m_data.angle_x !== e.angle_x) begin
                    $display("%0t: angle_x expected %h actual %h", $time, e.angle_x, m_data.angle_x);
                    errors++;
                end
                if (m_data.angle_y !== e.angle_y) begin
                    $display("%0t: angle_y expected %h actual %h", $time, e.angle_y, m_data.angle_y);
                    errors++;
                end
                if (m_data.angle_z !== e.angle_z) begin
                    $display("%0t: angle_z expected %h actual %h", $time, e.angle_z, m_data.angle_z);
                    errors++;
                end
                if (m_data.tilt_x !== e.tilt_x) begin
                    $display("%0t: tilt_x expected %0d actual %0d", $time, e.tilt_x, m_data.tilt_x);
                    errors++;
                end
                if (m_data.tilt_y !== e.tilt_y) begin
                    $display("%0t: tilt_y expected %0d actual %0d", $time, e.tilt_y, m_data.tilt_y);
                    errors++;
                end
            end
        end
        if (hold_request > 0) begin
            hold_count = hold_request;
            hold_request = 0;
        end
        if (hold_count > 0) begin
            hold_count--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_bias(logic [1:0] idx, logic [10:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx != CFG_NONE) gyro_bias[idx] = val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (sample_q.size() > 0 || s_valid || result_q.size() > 0) begin
            @(posedge aclk);
            #1;
        end
    endtask

    function automatic in_item_t random_sample();
        in_item_t d;
        d = {$urandom, $urandom, $urandom, 16'($urandom)};
        if ($urandom_range(99) < 15) begin
            d.acc_x = 16'($urandom_range(4)) - 16'd2;
            d.acc_y = 16'($urandom_range(4)) - 16'd2;
            d.acc_z = 16'($urandom_range(4)) - 16'd2;
        end
        if ($urandom_range(1)) d.elapsed_ms = 16'($urandom_range(50));
        return d;
    endfunction

    task automatic add_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                              logic [15:0] rx, logic [15:0] ry, logic [15:0] rz,
                              logic [15:0] el);
        in_item_t d;
        d = {ax, ay, az, rx, ry, rz, el};
        sample_q.push_back(d);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        write_bias(CFG_BIAS_X, 11'd0);
        write_bias(CFG_BIAS_Y, 11'd0);
        write_bias(CFG_BIAS_Z, 11'd0);
        add_sample(0, 0, 0, 0, 0, 0, 0);
        add_sample(0, 100, 0, 328, -328, 33, 1000);
        add_sample(0, -100, 0, 16'h8000, 16'h7fff, 0, 16'hffff);
        add_sample(5, 0, 0, 16'h7fff, 16'h8000, 16'hffff, 16'hffff);
        add_sample(-5, 0, 0, 1, -1, 0, 1);
        add_sample(16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0);
        add_sample(16'h7fff, 16'h7fff, 16'h7fff, 0, 0, 0, 0);
        add_sample(16'h8000, 0, 0, 0, 0, 0, 10);
        add_sample(0, 16'h7fff, 0, 0, 0, 0, 10);
        add_sample(0, 0, 16'h7fff, 0, 0, 0, 10);
        add_sample(0, 0, 16'h8000, 0, 0, 0, 10);
        add_sample(1, 16'h7fff, 1, 0, 0, 0, 10);
        add_sample(16'h8000, 1, 0, 0, 0, 0, 10);
        add_sample(16'h7fff, 16'h8000, 0, 16'h8000, 16'h8000, 16'h8000, 16'hffff);
        add_sample(3, 4, 0, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
        drain();
        write_bias(CFG_BIAS_X, 11'h400);
        write_bias(CFG_BIAS_Y, 11'h3ff);
        write_bias(CFG_BIAS_Z, -11'sd1000);
        write_bias(CFG_NONE, 11'h155);
        add_sample(0, 0, 0, 16'h7fff, 16'h8000, 0, 16'hffff);
        add_sample(1, 1, 1, 0, 0, 0, 16'hffff);
        add_sample(1, 1, 1, 16'h8000, 16'h7fff, 100, 16'hffff);
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            send_idle = (ph == 1 || ph == 3) ? 80 : 0;
            recv_stall = (ph == 2 || ph == 3) ? 80 : 0;
            if (ph == 3) begin
                send_idle = 6;
                recv_stall = 6;
            end
            write_bias(CFG_BIAS_X, ph == 0 ? 11'h3ff : 11'($urandom));
            write_bias(CFG_BIAS_Y, ph == 0 ? 11'h400 : 11'($urandom_range(2000) - 1000));
            write_bias(CFG_BIAS_Z, ph == 0 ? 11'd1000 : 11'($urandom));
            for (int i = 0; i < 165; i++) sample_q.push_back(random_sample());
            if (ph == 0) begin
                drain();
                hold_request = 3000;
                for (int i = 0; i < 20; i++) sample_q.push_back(random_sample());
            end
            drain();
        end
        repeat (400) @(posedge aclk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
